// ===== sv/tnds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tnds_pkg;

  localparam int unsigned TOP_COUNT = 8;
  localparam int unsigned RANK_OUT_LIMIT = 8;
  localparam int unsigned OUT_COUNT =
    (TOP_COUNT < RANK_OUT_LIMIT) ? TOP_COUNT : RANK_OUT_LIMIT;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RANK_W = 3;

  localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(OUT_COUNT - 1);

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      end_of_set;
  } in_t;

  typedef struct packed {
    logic [RANK_W-1:0]         rank_index;
    logic signed [VALUE_W-1:0] ranked_value;
    logic                      slot_valid;
    logic                      last_rank;
  } out_t;

  // commands broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift_up;
    logic clear;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/tnds_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tnds_cell (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire tnds_pkg::cell_cmd_t                  cmd_i,
  input  wire logic signed [tnds_pkg::VALUE_W-1:0]  sample_i,
  input  wire logic signed [tnds_pkg::VALUE_W-1:0]  prev_value_i,
  input  wire logic                                 prev_valid_i,
  input  wire logic                                 prev_greater_i,
  input  wire logic signed [tnds_pkg::VALUE_W-1:0]  next_value_i,
  input  wire logic                                 next_valid_i,
  output logic signed [tnds_pkg::VALUE_W-1:0]       value_o,
  output logic                                      valid_o,
  output logic                                      greater_o,
  output logic                                      equal_o
);

  logic signed [tnds_pkg::VALUE_W-1:0] value_q, value_d;
  logic                                valid_q, valid_d;

  // an empty slot takes anything, so the insert point is the first cell that says greater
  assign greater_o = !valid_q || (sample_i > value_q);
  assign equal_o   = valid_q && (sample_i == value_q);
  assign value_o   = value_q;
  assign valid_o   = valid_q;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (cmd_i.clear) begin
      value_d = tnds_pkg::INT_MIN;
      valid_d = 1'b0;
    end else if (cmd_i.shift_up) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end else if (cmd_i.insert) begin
      if (prev_greater_i) begin
        value_d = prev_value_i;
        valid_d = prev_valid_i;
      end else if (greater_o) begin
        value_d = sample_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= tnds_pkg::INT_MIN;
      valid_q <= 1'b0;
    end else begin
      value_q <= value_d;
      valid_q <= valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/top_n_distinct_selector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Keeps the largest distinct signed values of a data set in descending order.
// Input channel: in_i is transferred at a rising edge with start high and busy
// low. Each element is compared against every slot of the cell chain at once
// and inserted in the same cycle, so one element is taken per cycle while busy
// stays low. Repeats of a held value, and values below a full list, are dropped.
// When end_of_set is high the element is inserted first, then busy rises and
// the chain shifts towards rank 0 once a cycle: one result per cycle on
// result_o, marked by result_valid_o, ranks 0 to OUT_COUNT-1, the last one with
// last_rank set. On the cycle of the final rank the whole chain is cleared and
// busy falls. Empty ranks come out with the minimum integer and slot_valid low.
// The receiver cannot stall: every result is on the ports for one cycle only.
// Reset empties the list and ends any drain in progress.

module top_n_distinct_selector_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  wire tnds_pkg::in_t  in_i,
  output logic                result_valid_o,
  output tnds_pkg::out_t      result_o
);

  localparam int unsigned N = tnds_pkg::TOP_COUNT;

  logic signed [tnds_pkg::VALUE_W-1:0] cell_value [N];
  logic                                cell_valid [N];
  logic [N-1:0]                        cell_greater;
  logic [N-1:0]                        cell_equal;

  logic                       drain_q, drain_d;
  logic [tnds_pkg::RANK_W-1:0] rank_q, rank_d;
  logic                       take;
  logic                       duplicate;
  logic                       final_rank;
  tnds_pkg::cell_cmd_t        cmd;

  assign take       = start && !busy;
  assign duplicate  = |cell_equal;
  assign final_rank = drain_q && (rank_q == tnds_pkg::RANK_LAST);

  assign cmd.insert   = take && !duplicate;
  assign cmd.shift_up = drain_q;
  assign cmd.clear    = final_rank;

  for (genvar k = 0; k < N; k++) begin : g_chain
    logic signed [tnds_pkg::VALUE_W-1:0] prev_value, next_value;
    logic                                prev_valid, prev_greater, next_valid;

    if (k == 0) begin : g_head
      assign prev_value   = tnds_pkg::INT_MIN;
      assign prev_valid   = 1'b0;
      assign prev_greater = 1'b0;
    end else begin : g_body
      assign prev_value   = cell_value[k-1];
      assign prev_valid   = cell_valid[k-1];
      assign prev_greater = cell_greater[k-1];
    end

    if (k == N - 1) begin : g_tail
      assign next_value = tnds_pkg::INT_MIN;
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_value = cell_value[k+1];
      assign next_valid = cell_valid[k+1];
    end

    tnds_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .sample_i       (in_i.sample_value),
      .prev_value_i   (prev_value),
      .prev_valid_i   (prev_valid),
      .prev_greater_i (prev_greater),
      .next_value_i   (next_value),
      .next_valid_i   (next_valid),
      .value_o        (cell_value[k]),
      .valid_o        (cell_valid[k]),
      .greater_o      (cell_greater[k]),
      .equal_o        (cell_equal[k])
    );
  end

  always_comb begin
    drain_d = drain_q;
    rank_d  = rank_q;
    if (drain_q) begin
      if (final_rank) begin
        drain_d = 1'b0;
      end
      rank_d = rank_q + tnds_pkg::RANK_W'(1);
    end else if (take && in_i.end_of_set) begin
      drain_d = 1'b1;
      rank_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      drain_q <= drain_d;
      rank_q  <= rank_d;
    end
  end

  assign busy                  = drain_q;
  assign result_valid_o        = drain_q;
  assign result_o.rank_index   = rank_q;
  assign result_o.ranked_value = cell_value[0];
  assign result_o.slot_valid   = cell_valid[0];
  assign result_o.last_rank    = final_rank;

endmodule

`default_nettype wire

// ===== bench/top_n_distinct_selector_unit_tb.sv =====
`timescale 1ns / 1ps

module top_n_distinct_selector_unit_tb;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic signed [tnds_pkg::VALUE_W-1:0] INT_MAX = ~tnds_pkg::INT_MIN;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  tnds_pkg::in_t   in_i;
  logic            result_valid_o;
  tnds_pkg::out_t  result_o;

  top_n_distinct_selector_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // shadow of the ranked list, updated on every accepted element
  logic signed [tnds_pkg::VALUE_W-1:0] held_values [tnds_pkg::TOP_COUNT];
  int unsigned                         held_count;
  tnds_pkg::out_t                      pending_ranks [$];

  int unsigned error_count;
  int unsigned elements_sent;
  int unsigned sets_closed;
  int unsigned ranks_checked;
  int unsigned quiet_cycles;
  int unsigned sender_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void empty_held_list();
    for (int i = 0; i < tnds_pkg::TOP_COUNT; i++) begin
      held_values[i] = tnds_pkg::INT_MIN;
    end
    held_count = 0;
  endfunction

  function automatic void insert_element(logic signed [tnds_pkg::VALUE_W-1:0] value);
    int unsigned slot;
    slot = 0;
    while (slot < held_count && !(value > held_values[slot])) slot++;
    // below a full list, or a repeat of the value just above
    if (held_count >= tnds_pkg::TOP_COUNT && slot >= held_count) return;
    if (slot != 0 && held_values[slot-1] == value) return;
    for (int i = tnds_pkg::TOP_COUNT - 1; i > int'(slot); i--) begin
      held_values[i] = held_values[i-1];
    end
    held_values[slot] = value;
    if (held_count < tnds_pkg::TOP_COUNT) held_count++;
  endfunction

  function automatic void predict_ranks(tnds_pkg::in_t item);
    tnds_pkg::out_t rank;
    insert_element(item.sample_value);
    if (item.end_of_set) begin
      for (int k = 0; k < tnds_pkg::OUT_COUNT; k++) begin
        rank.rank_index   = tnds_pkg::RANK_W'(k);
        rank.ranked_value = held_values[k];
        rank.slot_valid   = (k < held_count);
        rank.last_rank    = (k == tnds_pkg::OUT_COUNT - 1);
        pending_ranks.push_back(rank);
      end
      empty_held_list();
      sets_closed++;
    end
  endfunction

  function automatic void check_rank(tnds_pkg::out_t got);
    tnds_pkg::out_t want;
    if (pending_ranks.size() == 0) begin
      $display("%0t: unexpected rank result %p", $time, got);
      error_count++;
      return;
    end
    want = pending_ranks.pop_front();
    ranks_checked++;
    if (got.rank_index !== want.rank_index) begin
      $display("%0t: rank_index expected %0d got %0d", $time, want.rank_index,
               got.rank_index);
      error_count++;
    end
    if (got.ranked_value !== want.ranked_value) begin
      $display("%0t: ranked_value (rank %0d) expected %0d got %0d", $time,
               want.rank_index, want.ranked_value, got.ranked_value);
      error_count++;
    end
    if (got.slot_valid !== want.slot_valid) begin
      $display("%0t: slot_valid (rank %0d) expected %b got %b", $time,
               want.rank_index, want.slot_valid, got.slot_valid);
      error_count++;
    end
    if (got.last_rank !== want.last_rank) begin
      $display("%0t: last_rank (rank %0d) expected %b got %b", $time,
               want.rank_index, want.last_rank, got.last_rank);
      error_count++;
    end
  endfunction

  // results first, then the element taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) check_rank(result_o);
      if (start && !busy) predict_ranks(in_i);
      if (result_valid_o || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_sample(input logic signed [tnds_pkg::VALUE_W-1:0] value,
                             input logic last);
    tnds_pkg::in_t item;
    item.sample_value = value;
    item.end_of_set   = last;
    if (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
      start <= 1'b0;
      in_i  <= {$urandom, 1'($urandom_range(0, 1))};
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= item;
    do @(posedge clk_i); while (busy);
    elements_sent++;
  endtask

  function automatic logic signed [tnds_pkg::VALUE_W-1:0] pick_value(int unsigned flavour);
    case (flavour)
      0: return $signed(tnds_pkg::VALUE_W'($urandom_range(0, 12))) - 6;
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return tnds_pkg::INT_MIN;
          1: return INT_MAX;
          2: return '0;
          3: return '1;
          4: return tnds_pkg::INT_MIN + 1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic test_lone_minimum();
    // the minimum integer is a real element and fills rank 0
    send_sample(tnds_pkg::INT_MIN, 1'b1);
  endtask

  task automatic test_repeats();
    send_sample(tnds_pkg::INT_MIN, 1'b0);
    send_sample(tnds_pkg::INT_MIN, 1'b0);
    send_sample(INT_MAX, 1'b0);
    send_sample(INT_MAX, 1'b0);
    send_sample(5, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(5, 1'b1);
  endtask

  task automatic test_overflow();
    // ascending run pushes the oldest entries off the bottom
    for (int v = 1; v <= 10; v++) send_sample(v, 1'b0);
    send_sample(0, 1'b0);
    send_sample(tnds_pkg::INT_MIN, 1'b1);
  endtask

  task automatic test_random_sets(input int unsigned idle_pct, input int unsigned budget);
    int unsigned first;
    int unsigned set_length;
    int unsigned flavour;
    sender_idle_pct = idle_pct;
    first = elements_sent;
    while (elements_sent - first < budget) begin
      set_length = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24)
                                              : $urandom_range(1, 12);
      flavour = $urandom_range(0, 2);
      for (int i = 0; i < set_length; i++) begin
        send_sample(pick_value(flavour), i == set_length - 1);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    in_i            = '0;
    sender_idle_pct = 0;
    error_count     = 0;
    elements_sent   = 0;
    sets_closed     = 0;
    ranks_checked   = 0;
    quiet_cycles    = 0;
    empty_held_list();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 34;
    test_lone_minimum();
    test_repeats();
    test_overflow();
    test_random_sets(34, 100);
    test_random_sets(47, 100);
    test_random_sets(0, 100);

    start <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk_i);
    repeat (tnds_pkg::OUT_COUNT + 4) @(posedge clk_i);

    $display("%0d elements in %0d sets, %0d ranks checked", elements_sent, sets_closed,
             ranks_checked);
    $display("covered repeats, extremes, full-list drops and sender gaps of 0/34/47 pct");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tnds_pkg.sv
sv/tnds_cell.sv
sv/top_n_distinct_selector_unit.sv
bench/top_n_distinct_selector_unit_tb.sv
